// ===== rtl/amcc_pkg.sv =====
// Shared types and constants of the box mover: request layout, codes, control structs.
package amcc_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;

   localparam int REQ_BITS     = 168;
   localparam int RSP_BITS     = 104;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_BITS     = 32;

   // Request kinds carried on req_tuser.
   localparam logic [1:0] MODE_PLACE = 2'd0;
   localparam logic [1:0] MODE_STEP  = 2'd1;
   localparam logic [1:0] MODE_OBST  = 2'd2;

   // Register indexes on the csr port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BOX_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACCEL_X    = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACCEL_Y    = 2'd3;

   // Request payload, first field in the lowest bits.
   typedef struct packed {
      logic [5:0]                   pad;
      logic [11:0]                  obst_h;
      logic [11:0]                  obst_w;
      logic signed [15:0]           obst_y;
      logic signed [15:0]           obst_x;
      logic signed [31:0]           place_vel_y;
      logic signed [31:0]           place_vel_x;
      logic signed [COORD_BITS-1:0] place_y;
      logic signed [COORD_BITS-1:0] place_x;
      logic [9:0]                   delta_ms;
   } req_data_type;

   // Result payload, first field in the lowest bits.
   typedef struct packed {
      logic [5:0]                   pad;
      logic                         hit_y;
      logic                         hit_x;
      logic signed [31:0]           new_vel_y;
      logic signed [31:0]           new_vel_x;
      logic signed [COORD_BITS-1:0] new_y;
      logic signed [COORD_BITS-1:0] new_x;
   } rsp_data_type;

   typedef struct packed {
      logic load;
      logic place;
      logic accel;
      logic offset;
      logic test;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req_mode;
      logic       item_last;
      logic       out_free;
   } stat_type;

endpackage

// ===== rtl/amcc_ctrl.sv =====
// Sequencer of the box mover: decodes requests and steps the datapath through each one.
module amcc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  amcc_pkg::stat_type stat,
   output amcc_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PLACE,
      ST_ACCEL,
      ST_OFFSET,
      ST_TEST,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;
   logic      in_step_ff, in_step_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      in_step_in = in_step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (stat.req_mode)
                  amcc_pkg::MODE_PLACE: state_in = ST_PLACE;
                  amcc_pkg::MODE_STEP:  state_in = ST_ACCEL;
                  amcc_pkg::MODE_OBST:  state_in = in_step_ff ? ST_TEST : ST_IDLE;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_PLACE: begin
            in_step_in = 1'b0;
            state_in   = ST_IDLE;
         end
         ST_ACCEL: begin
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            in_step_in = 1'b1;
            state_in   = stat.item_last ? ST_COMMIT : ST_IDLE;
         end
         ST_TEST: begin
            state_in = stat.item_last ? ST_COMMIT : ST_IDLE;
         end
         ST_COMMIT: begin
            // hold until the result slot is free
            if (stat.out_free) begin
               in_step_in = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         in_step_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         in_step_ff <= in_step_in;
      end
   end

   always_comb begin
      cmd.load   = accept;
      cmd.place  = (state_ff == ST_PLACE);
      cmd.accel  = (state_ff == ST_ACCEL);
      cmd.offset = (state_ff == ST_OFFSET);
      cmd.test   = (state_ff == ST_TEST);
      cmd.commit = (state_ff == ST_COMMIT) && stat.out_free;
   end

endmodule

// ===== rtl/amcc_datapath.sv =====
// Datapath of the box mover: settings, motion state, step math, overlap clamp, result register.
module amcc_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [amcc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [amcc_pkg::CSR_BITS-1:0]       csr_wdata,
   input  logic [amcc_pkg::REQ_BITS-1:0]       req_tdata,
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tlast,
   output logic [amcc_pkg::RSP_BITS-1:0]       rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  amcc_pkg::cmd_type                   cmd,
   output amcc_pkg::stat_type                  stat
);

   localparam int CB = amcc_pkg::COORD_BITS;

   typedef struct packed {
      logic signed [31:0] limit;
      logic               stop;
   } clamp_type;

   function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
      logic signed [43:0] hi;
      logic signed [43:0] lo;
      hi = 44'sd2147483647;
      lo = -44'sd2147483648;
      if (v > hi) begin
         return hi[31:0];
      end else if (v < lo) begin
         return lo[31:0];
      end
      return v[31:0];
   endfunction

   function automatic logic signed [CB-1:0] sat_coord(input logic signed [32:0] v);
      logic signed [32:0] hi;
      logic signed [32:0] lo;
      hi = 33'((64'sd1 <<< (CB - 1)) - 64'sd1);
      lo = -hi - 33'sd1;
      if (v > hi) begin
         return hi[CB-1:0];
      end else if (v < lo) begin
         return lo[CB-1:0];
      end
      return v[CB-1:0];
   endfunction

   // velocity times delta, truncated toward zero to whole pixels
   function automatic logic signed [31:0] offset_of(input logic signed [31:0] vel,
                                                    input logic [9:0] d);
      logic signed [42:0] p;
      logic [42:0]        mag;
      logic [42:0]        shr;
      logic signed [42:0] r;
      p   = $signed({1'b0, d}) * vel;
      mag = p[42] ? 43'(-p) : 43'(p);
      shr = mag >> amcc_pkg::FRAC_BITS;
      r   = p[42] ? -$signed(shr) : $signed(shr);
      return sat32(44'(r));
   endfunction

   function automatic logic overlap_axis(input logic signed [CB-1:0] pos,
                                         input logic signed [31:0] want,
                                         input logic [11:0] size,
                                         input logic signed [15:0] opos,
                                         input logic [11:0] osize);
      logic signed [33:0] m;
      logic signed [33:0] sz;
      logic signed [33:0] osz;
      m   = 34'(pos) + 34'(want);
      sz  = $signed({22'd0, size});
      osz = $signed({22'd0, osize});
      return (size != 12'd0) && (osize != 12'd0) &&
             (m < 34'(opos) + osz) && (34'(opos) < m + sz);
   endfunction

   function automatic clamp_type clamp_axis(input logic signed [31:0] want,
                                            input logic signed [31:0] limit,
                                            input logic signed [CB-1:0] pos,
                                            input logic [11:0] size,
                                            input logic signed [15:0] opos,
                                            input logic [11:0] osize);
      logic signed [33:0] gap_fwd;
      logic signed [33:0] gap_back;
      logic signed [33:0] lim;
      clamp_type          r;
      gap_fwd  = 34'(opos) - 34'(pos) - $signed({22'd0, size});
      gap_back = 34'(opos) + $signed({22'd0, osize}) - 34'(pos);
      lim      = 34'(limit);
      r.limit  = limit;
      r.stop   = 1'b0;
      if (!want[31] && (want != 32'sd0)) begin
         // moving forward: stop at the near edge of the obstacle
         if (!gap_fwd[33] && (gap_fwd < lim)) begin
            r.limit = gap_fwd[31:0];
            r.stop  = 1'b1;
         end
      end else if (want[31]) begin
         if ((gap_back[33] || (gap_back == 34'sd0)) && (gap_back > lim)) begin
            r.limit = gap_back[31:0];
            r.stop  = 1'b1;
         end
      end
      return r;
   endfunction

   amcc_pkg::req_data_type item_ff;
   logic                   item_last_ff;

   logic [11:0]            box_w_ff, box_w_in;
   logic [11:0]            box_h_ff, box_h_in;
   logic signed [31:0]     accel_x_ff, accel_x_in;
   logic signed [31:0]     accel_y_ff, accel_y_in;

   logic signed [CB-1:0]   cur_x_ff, cur_x_in;
   logic signed [CB-1:0]   cur_y_ff, cur_y_in;
   logic signed [31:0]     vel_x_ff, vel_x_in;
   logic signed [31:0]     vel_y_ff, vel_y_in;
   logic signed [31:0]     want_x_ff, want_x_in;
   logic signed [31:0]     want_y_ff, want_y_in;
   logic signed [31:0]     limit_x_ff, limit_x_in;
   logic signed [31:0]     limit_y_ff, limit_y_in;
   logic                   stop_x_ff, stop_x_in;
   logic                   stop_y_ff, stop_y_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   amcc_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic signed [42:0]     dvx;
   logic signed [42:0]     dvy;
   logic                   hit;
   clamp_type              cl_x;
   clamp_type              cl_y;
   logic signed [32:0]     sum_x;
   logic signed [32:0]     sum_y;
   logic signed [CB-1:0]   com_x;
   logic signed [CB-1:0]   com_y;
   logic signed [31:0]     com_vx;
   logic signed [31:0]     com_vy;

   assign stat.req_mode  = req_tuser;
   assign stat.item_last = item_last_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      box_w_in   = box_w_ff;
      box_h_in   = box_h_ff;
      accel_x_in = accel_x_ff;
      accel_y_in = accel_y_ff;
      if (csr_we) begin
         case (csr_index)
            amcc_pkg::CSR_BOX_WIDTH:  box_w_in   = csr_wdata[11:0];
            amcc_pkg::CSR_BOX_HEIGHT: box_h_in   = csr_wdata[11:0];
            amcc_pkg::CSR_ACCEL_X:    accel_x_in = csr_wdata;
            amcc_pkg::CSR_ACCEL_Y:    accel_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      dvx = $signed({1'b0, item_ff.delta_ms}) * accel_x_ff;
      dvy = $signed({1'b0, item_ff.delta_ms}) * accel_y_ff;

      hit = overlap_axis(cur_x_ff, want_x_ff, box_w_ff, item_ff.obst_x, item_ff.obst_w) &&
            overlap_axis(cur_y_ff, want_y_ff, box_h_ff, item_ff.obst_y, item_ff.obst_h);
      cl_x = clamp_axis(want_x_ff, limit_x_ff, cur_x_ff, box_w_ff,
                        item_ff.obst_x, item_ff.obst_w);
      cl_y = clamp_axis(want_y_ff, limit_y_ff, cur_y_ff, box_h_ff,
                        item_ff.obst_y, item_ff.obst_h);

      sum_x  = 33'(cur_x_ff) + 33'(limit_x_ff);
      sum_y  = 33'(cur_y_ff) + 33'(limit_y_ff);
      com_x  = sat_coord(sum_x);
      com_y  = sat_coord(sum_y);
      com_vx = stop_x_ff ? 32'sd0 : vel_x_ff;
      com_vy = stop_y_ff ? 32'sd0 : vel_y_ff;

      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      vel_x_in   = vel_x_ff;
      vel_y_in   = vel_y_ff;
      want_x_in  = want_x_ff;
      want_y_in  = want_y_ff;
      limit_x_in = limit_x_ff;
      limit_y_in = limit_y_ff;
      stop_x_in  = stop_x_ff;
      stop_y_in  = stop_y_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (cmd.place) begin
         cur_x_in = item_ff.place_x;
         cur_y_in = item_ff.place_y;
         vel_x_in = item_ff.place_vel_x;
         vel_y_in = item_ff.place_vel_y;
      end
      if (cmd.accel) begin
         vel_x_in = sat32(44'(vel_x_ff) + 44'(dvx));
         vel_y_in = sat32(44'(vel_y_ff) + 44'(dvy));
      end
      if (cmd.offset) begin
         want_x_in  = offset_of(vel_x_ff, item_ff.delta_ms);
         want_y_in  = offset_of(vel_y_ff, item_ff.delta_ms);
         limit_x_in = want_x_in;
         limit_y_in = want_y_in;
         stop_x_in  = 1'b0;
         stop_y_in  = 1'b0;
      end
      if (cmd.test && hit) begin
         limit_x_in = cl_x.limit;
         limit_y_in = cl_y.limit;
         stop_x_in  = stop_x_ff || cl_x.stop;
         stop_y_in  = stop_y_ff || cl_y.stop;
      end
      if (cmd.commit) begin
         cur_x_in              = com_x;
         cur_y_in              = com_y;
         vel_x_in              = com_vx;
         vel_y_in              = com_vy;
         rsp_valid_in          = 1'b1;
         rsp_data_in.pad       = '0;
         rsp_data_in.new_x     = com_x;
         rsp_data_in.new_y     = com_y;
         rsp_data_in.new_vel_x = com_vx;
         rsp_data_in.new_vel_y = com_vy;
         rsp_data_in.hit_x     = stop_x_ff;
         rsp_data_in.hit_y     = stop_y_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_w_ff     <= 12'd16;
         box_h_ff     <= 12'd16;
         accel_x_ff   <= '0;
         accel_y_ff   <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         want_x_ff    <= '0;
         want_y_ff    <= '0;
         limit_x_ff   <= '0;
         limit_y_ff   <= '0;
         stop_x_ff    <= 1'b0;
         stop_y_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         box_w_ff     <= box_w_in;
         box_h_ff     <= box_h_in;
         accel_x_ff   <= accel_x_in;
         accel_y_ff   <= accel_y_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         want_x_ff    <= want_x_in;
         want_y_ff    <= want_y_in;
         limit_x_ff   <= limit_x_in;
         limit_y_ff   <= limit_y_in;
         stop_x_ff    <= stop_x_in;
         stop_y_ff    <= stop_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (cmd.load) begin
         item_ff      <= req_tdata;
         item_last_ff <= req_tlast;
      end
   end

endmodule

// ===== rtl/aabb_move_collision_clamp.sv =====
// Top level of the swept box mover: sequencer plus datapath.
//
// Requests arrive on req_* (stream handshake). req_tuser selects place, step or
// obstacle; req_tlast marks the last obstacle of a move (on a step: no obstacles).
// A completed move leaves one result on rsp_*; place requests, stray obstacles and
// unused kinds give none. csr_* writes box size and acceleration, one register per
// cycle; the user must write only while the block is idle: no logic enforces it.
// A place request passes through the place state, an obstacle of an open move through
// the test state and a step through the accel and offset states; a step or an obstacle
// of an open move with req_tlast set then moves on to the commit state. The
// step path is set by two dependent multiplies (acceleration, then offset), each in
// a state of its own; the obstacle path by the overlap compare and clamp (test state).
// Reset clears position, velocity and the open move; size returns to 16 x 16 and
// acceleration to zero. A result waits in the output register while rsp_tready is
// low; the block keeps taking requests until it needs to commit the next result,
// and then holds req_tready low until the register is free.
module aabb_move_collision_clamp (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [amcc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [amcc_pkg::CSR_BITS-1:0]     csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // delta_ms, place_x, place_y, place_vel_x, place_vel_y, obst_x, obst_y, obst_w, obst_h
   input  logic [amcc_pkg::REQ_BITS-1:0]     req_tdata,
   // mode
   input  logic [1:0]                        req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // new_x, new_y, new_vel_x, new_vel_y, hit_x, hit_y
   output logic [amcc_pkg::RSP_BITS-1:0]     rsp_tdata
);

   amcc_pkg::cmd_type  cmd;
   amcc_pkg::stat_type stat;

   amcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   amcc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

// ===== rtl/amcc_checker.sv =====
// Port-level checks of the box mover, bound to the top level.
module amcc_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [1:0]                        req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [amcc_pkg::RSP_BITS-1:0]     rsp_tdata
);

   amcc_pkg::rsp_data_type rsp;
   assign rsp = rsp_tdata;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or dropped");

   a_one_per_cycle: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      (req_tuser == amcc_pkg::MODE_PLACE || req_tuser == amcc_pkg::MODE_STEP)
      |=> !req_tready)
      else $error("request taken in back-to-back cycles");

   a_commit_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared while the block was idle");

   a_hit_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp.hit_x || rsp.new_vel_x == 32'sd0) &&
                     (!rsp.hit_y || rsp.new_vel_y == 32'sd0))
      else $error("stopped axis kept its velocity");

endmodule

bind aabb_move_collision_clamp amcc_checker u_amcc_checker (.*);

// ===== bench/amcc_move_checker.sv =====
`timescale 1ns / 1ps
// Move checker: tracks the box mover from its request and register traffic and compares results.
module amcc_move_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [amcc_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [amcc_pkg::CSR_BITS-1:0]     csr_wdata,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [amcc_pkg::REQ_BITS-1:0]     req_tdata,
   input  logic [1:0]                        req_tuser,
   input  logic                              req_tlast,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [amcc_pkg::RSP_BITS-1:0]     rsp_tdata,
   output int                                mismatch_count,
   output int                                moves_due_count
);
   import amcc_pkg::*;

   // Register copies.
   longint box_w, box_h, acc_x, acc_y;
   // Mover state.
   longint pos_x, pos_y, vel_x, vel_y;
   longint want_dx, want_dy, lim_dx, lim_dy;
   bit     halt_x, halt_y, move_open;

   rsp_data_type due_moves[$];
   int           n_bad = 0;

   function automatic longint clip(input longint v, input int bits);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Whole pixels moved in d ms, truncated toward zero.
   function automatic longint pixel_offset(input longint vel, input longint d);
      longint p;
      p = vel * d;
      if (p < 0) return clip(-((-p) >>> FRAC_BITS), 32);
      return clip(p >>> FRAC_BITS, 32);
   endfunction

   // Shrink the offset to the gap ahead of the leading edge.
   function automatic void clamp_gap(input longint want, inout longint lim, inout bit halt,
                                     input longint pos, input longint size,
                                     input longint o_pos, input longint o_size);
      longint gap;
      if (want > 0) begin
         gap = o_pos - (pos + size);
         if (gap >= 0 && gap < lim) begin
            lim  = gap;
            halt = 1'b1;
         end
      end else if (want < 0) begin
         gap = (o_pos + o_size) - pos;
         if (gap <= 0 && gap > lim) begin
            lim  = gap;
            halt = 1'b1;
         end
      end
   endfunction

   function automatic void close_move();
      rsp_data_type r;
      pos_x = clip(pos_x + lim_dx, COORD_BITS);
      pos_y = clip(pos_y + lim_dy, COORD_BITS);
      if (halt_x) vel_x = 0;
      if (halt_y) vel_y = 0;
      r           = '0;
      r.new_x     = pos_x[COORD_BITS-1:0];
      r.new_y     = pos_y[COORD_BITS-1:0];
      r.new_vel_x = vel_x[31:0];
      r.new_vel_y = vel_y[31:0];
      r.hit_x     = halt_x;
      r.hit_y     = halt_y;
      due_moves.push_back(r);
      move_open = 1'b0;
   endfunction

   always @(posedge clock) begin
      rsp_data_type got;
      rsp_data_type want;
      req_data_type pay;
      longint       dms, ox, oy, ow, oh, mx, my;
      if (reset) begin
         box_w     = 16;
         box_h     = 16;
         acc_x     = 0;
         acc_y     = 0;
         pos_x     = 0;
         pos_y     = 0;
         vel_x     = 0;
         vel_y     = 0;
         want_dx   = 0;
         want_dy   = 0;
         lim_dx    = 0;
         lim_dy    = 0;
         halt_x    = 1'b0;
         halt_y    = 1'b0;
         move_open = 1'b0;
         due_moves.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (due_moves.size() == 0) begin
               n_bad++;
               if (n_bad <= 10)
                  $display("%0t: move result with none outstanding: x=%0d y=%0d vx=%0d vy=%0d hit=%b%b",
                           $time, got.new_x, got.new_y, got.new_vel_x, got.new_vel_y,
                           got.hit_x, got.hit_y);
            end else begin
               want = due_moves.pop_front();
               if (got.new_x !== want.new_x || got.new_y !== want.new_y ||
                   got.new_vel_x !== want.new_vel_x || got.new_vel_y !== want.new_vel_y ||
                   got.hit_x !== want.hit_x || got.hit_y !== want.hit_y) begin
                  n_bad++;
                  if (n_bad <= 10)
                     $display("%0t: move result differs: expected x=%0d y=%0d vx=%0d vy=%0d hit=%b%b, got x=%0d y=%0d vx=%0d vy=%0d hit=%b%b",
                              $time, want.new_x, want.new_y, want.new_vel_x, want.new_vel_y,
                              want.hit_x, want.hit_y, got.new_x, got.new_y, got.new_vel_x,
                              got.new_vel_y, got.hit_x, got.hit_y);
               end
            end
         end

         if (csr_we) begin
            case (csr_index)
               CSR_BOX_WIDTH:  box_w = csr_wdata[11:0];
               CSR_BOX_HEIGHT: box_h = csr_wdata[11:0];
               CSR_ACCEL_X:    acc_x = $signed(csr_wdata);
               CSR_ACCEL_Y:    acc_y = $signed(csr_wdata);
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            pay = req_tdata;
            dms = pay.delta_ms;
            case (req_tuser)
               MODE_PLACE: begin
                  pos_x     = $signed(pay.place_x);
                  pos_y     = $signed(pay.place_y);
                  vel_x     = $signed(pay.place_vel_x);
                  vel_y     = $signed(pay.place_vel_y);
                  move_open = 1'b0;
               end
               MODE_STEP: begin
                  vel_x     = clip(vel_x + dms * acc_x, 32);
                  vel_y     = clip(vel_y + dms * acc_y, 32);
                  want_dx   = pixel_offset(vel_x, dms);
                  want_dy   = pixel_offset(vel_y, dms);
                  lim_dx    = want_dx;
                  lim_dy    = want_dy;
                  halt_x    = 1'b0;
                  halt_y    = 1'b0;
                  move_open = 1'b1;
                  if (req_tlast) close_move();
               end
               MODE_OBST: begin
                  // Drop obstacles that arrive with no move open.
                  if (move_open) begin
                     ox = $signed(pay.obst_x);
                     oy = $signed(pay.obst_y);
                     ow = pay.obst_w;
                     oh = pay.obst_h;
                     mx = pos_x + want_dx;
                     my = pos_y + want_dy;
                     if (box_w > 0 && box_h > 0 && ow > 0 && oh > 0 &&
                         mx < ox + ow && ox < mx + box_w &&
                         my < oy + oh && oy < my + box_h) begin
                        clamp_gap(want_dx, lim_dx, halt_x, pos_x, box_w, ox, ow);
                        clamp_gap(want_dy, lim_dy, halt_y, pos_y, box_h, oy, oh);
                     end
                     if (req_tlast) close_move();
                  end
               end
               default: ;
            endcase
         end
      end
      mismatch_count  <= n_bad;
      moves_due_count <= due_moves.size();
   end

endmodule

// ===== bench/tb_aabb_move_collision_clamp.sv =====
`timescale 1ns / 1ps
// Testbench top: drives requests and register writes into the box mover and gives the verdict.
module tb_aabb_move_collision_clamp;
   import amcc_pkg::*;

   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         SETTLE_CYCLES = 8;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index  = '0;
   logic [CSR_BITS-1:0]     csr_wdata  = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_BITS-1:0]     req_tdata  = '0;
   logic [1:0]              req_tuser  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]     rsp_tdata;

   int mismatch_count;
   int moves_due_count;
   int tx_idle_pct = 29;
   int rx_idle_pct = 46;
   int cycle_count = 0;
   int center_x    = 0;
   int center_y    = 0;

   always #6 clock = ~clock;

   aabb_move_collision_clamp u_dut (.*);

   amcc_move_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

   task automatic send_req(input logic [1:0] kind, input req_data_type pay, input logic fin);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= pay;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Fill every field but pad with noise so unused ones toggle too.
   function automatic req_data_type noise_payload();
      logic [191:0] raw;
      req_data_type pay;
      raw     = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      pay     = raw[REQ_BITS-1:0];
      pay.pad = '0;
      return pay;
   endfunction

   task automatic send_place(input int x, input int y, input int vx, input int vy);
      req_data_type pay;
      pay             = noise_payload();
      pay.place_x     = 16'(x);
      pay.place_y     = 16'(y);
      pay.place_vel_x = vx;
      pay.place_vel_y = vy;
      send_req(MODE_PLACE, pay, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_step(input int d, input logic fin);
      req_data_type pay;
      pay          = noise_payload();
      pay.delta_ms = 10'(d);
      send_req(MODE_STEP, pay, fin);
   endtask

   task automatic send_obst(input int x, input int y, input int w, input int h,
                            input logic fin);
      req_data_type pay;
      pay        = noise_payload();
      pay.obst_x = 16'(x);
      pay.obst_y = 16'(y);
      pay.obst_w = 12'(w);
      pay.obst_h = 12'(h);
      send_req(MODE_OBST, pay, fin);
   endtask

   // Hold off the sender until every result is back and the block has settled.
   task automatic wait_moves_done();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (moves_due_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic set_mover(input int w, input int h, input int ax, input int ay);
      wait_moves_done();
      write_reg(CSR_BOX_WIDTH, w);
      write_reg(CSR_BOX_HEIGHT, h);
      write_reg(CSR_ACCEL_X, ax);
      write_reg(CSR_ACCEL_Y, ay);
      csr_we <= 1'b0;
   endtask

   function automatic int small_accel();
      return int'($urandom_range(0, 1 << 15)) - (1 << 14);
   endfunction

   function automatic int pick_velocity();
      if ($urandom_range(0, 19) == 0) return int'($urandom);
      return int'($urandom_range(0, 12 << 16)) - (6 << 16);
   endfunction

   task automatic run_moves(input int n_items);
      int         sent;
      int         n_obs;
      int         ow;
      int         oh;
      logic [1:0] kind;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 99) < 12) begin
            kind = 2'($urandom_range(0, 3));
            send_req(kind, noise_payload(), 1'($urandom_range(0, 1)));
            if (kind != MODE_UNUSED) sent++;
         end else begin
            if ($urandom_range(0, 99) < 35) begin
               if ($urandom_range(0, 19) == 0) begin
                  center_x = int'($urandom_range(0, 65535)) - 32768;
                  center_y = int'($urandom_range(0, 65535)) - 32768;
               end else begin
                  center_x = int'($urandom_range(0, 400)) - 200;
                  center_y = int'($urandom_range(0, 400)) - 200;
               end
               send_place(center_x, center_y, pick_velocity(), pick_velocity());
               sent++;
            end
            n_obs = $urandom_range(0, 5);
            send_step(($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                  : $urandom_range(0, 24), n_obs == 0);
            sent++;
            for (int i = 0; i < n_obs; i++) begin
               if ($urandom_range(0, 24) == 0) begin
                  ow = $urandom_range(0, 4095);
                  oh = $urandom_range(0, 4095);
               end else begin
                  ow = $urandom_range(0, 60);
                  oh = $urandom_range(0, 60);
               end
               // Leave a move open now and then.
               send_obst(center_x + int'($urandom_range(0, 240)) - 120,
                         center_y + int'($urandom_range(0, 240)) - 120, ow, oh,
                         (i == n_obs - 1) && ($urandom_range(0, 19) != 0));
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      set_mover(16, 16, 0, 0);
      send_step(0, 1'b1);
      send_place(0, 0, 4 <<< 16, -(2 <<< 16));
      send_step(10, 1'b0);
      send_obst(50, -30, 20, 20, 1'b0);     // clamps both axes
      send_obst(56, -20, 20, 16, 1'b0);     // shares the leading edge only
      send_obst(40, -20, 0, 16, 1'b1);      // empty obstacle
      send_obst(0, 0, 100, 100, 1'b1);      // no open move
      send_req(MODE_UNUSED, noise_payload(), 1'b1);
      send_place(100, 100, -(3 <<< 16) + 'h8000, 0);
      send_step(7, 1'b0);
      send_place(-100, -100, 1 <<< 16, 1 <<< 16);  // drops the open move
      send_step(5, 1'b0);
      send_step(3, 1'b0);                   // restarts the move
      send_obst(-95, -95, 10, 10, 1'b1);
      send_place(100, 0, -(10 <<< 16), 0);
      send_step(2, 1'b0);
      send_obst(70, -5, 20, 10, 1'b1);      // left-moving hit, y not moving
      send_place(0, 0, 0, 3 <<< 16);
      send_step(10, 1'b0);
      send_obst(-5, 40, 30, 20, 1'b1);      // downward hit
      send_place(32767, -32768, 32'h7fffffff, 32'h80000000);
      send_step(1023, 1'b1);
      send_obst(-32768, -32768, 4095, 4095, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct = 29;
               rx_idle_pct = 46;
            end
            1: begin
               tx_idle_pct = 46;
               rx_idle_pct = 29;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         set_mover($urandom_range(1, 48), $urandom_range(1, 48), small_accel(), small_accel());
         run_moves(150);
         case (phase)
            0:       set_mover(0, 4095, 32'h7fffffff, 32'h80000000);
            1:       set_mover(4095, 0, 32'h80000000, 32'h7fffffff);
            default: set_mover(4095, 4095, 0, 0);
         endcase
         run_moves(50);
      end

      wait_moves_done();
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
